// File: sv/tlbpt_pkg.sv
// Shared types and constants for the TLB / page table translator.
// No dependencies.
`default_nettype none
package tlbpt_pkg;
    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;
    localparam int OFFSET_BITS = 8;
    localparam int ADDR_BITS   = 16;
    localparam int PAGE_BITS   = $clog2(PAGE_COUNT);
    localparam int FRAME_BITS  = $clog2(FRAME_COUNT);
    localparam int TLB_IDX     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FILL_BITS   = $clog2(TLB_ENTRIES + 1);
    localparam int FRAME_OUT   = 8;
    localparam int CNT_BITS    = 32;
    localparam int QDEPTH      = 2;

    typedef logic [PAGE_BITS-1:0]   page_t;
    typedef logic [FRAME_BITS-1:0]  frame_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } back_state_t;

    // Classified item passed from front to back
    typedef struct packed {
        page_t   page;
        offset_t offset;
        logic    hit;
        frame_t  frame;
    } work_t;

    // Fault report from back to front, refills the TLB
    typedef struct packed {
        logic   push;
        page_t  page;
        frame_t frame;
    } refill_t;
endpackage
`default_nettype wire

// File: sv/tlbpt_front.sv
// Front end: accepts addresses, searches the TLB, queues classified items.
// Depends on tlbpt_pkg.
`default_nettype none
module tlbpt_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            valid,
    output logic                                 ready,
    input  wire logic [tlbpt_pkg::ADDR_BITS-1:0] logical_address,
    output logic                                 q_valid,
    input  wire logic                            q_ready,
    output tlbpt_pkg::work_t                     q_data,
    input  wire tlbpt_pkg::refill_t              refill,
    input  wire logic                            back_idle
);
    tlbpt_pkg::page_t  tlb_page_reg  [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::frame_t tlb_frame_reg [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::FILL_BITS-1:0] fill_reg;
    tlbpt_pkg::work_t q_mem_reg [tlbpt_pkg::QDEPTH];
    logic [1:0] q_cnt_reg;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       busy_reg;   // one item in flight until the back finishes it

    tlbpt_pkg::work_t  cls;
    logic              push, pop;

    always_comb
    begin
        cls.page   = logical_address[tlbpt_pkg::OFFSET_BITS +: tlbpt_pkg::PAGE_BITS];
        cls.offset = logical_address[tlbpt_pkg::OFFSET_BITS-1:0];
        cls.hit    = 1'b0;
        cls.frame  = '0;
        // ascending order, so the oldest matching entry wins
        for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
        begin
            if ((i < int'(fill_reg)) && (tlb_page_reg[i] == cls.page))
            begin
                cls.hit   = 1'b1;
                cls.frame = tlb_frame_reg[i];
            end
        end
    end

    assign ready   = !busy_reg && (q_cnt_reg != 2'(tlbpt_pkg::QDEPTH));
    assign push    = valid && ready;
    assign q_valid = (q_cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= cls;
        if (refill.push)
        begin
            for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i > 0; i--)
            begin
                tlb_page_reg[i]  <= tlb_page_reg[i-1];
                tlb_frame_reg[i] <= tlb_frame_reg[i-1];
            end
            tlb_page_reg[0]  <= refill.page;
            tlb_frame_reg[0] <= refill.frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            q_cnt_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            if (refill.push && (fill_reg != tlbpt_pkg::FILL_BITS'(tlbpt_pkg::TLB_ENTRIES)))
                fill_reg <= fill_reg + 1'b1;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(pop);
            if (push)
                busy_reg <= 1'b1;
            else if (back_idle && !q_valid)
                busy_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: sv/tlbpt_back.sv
// Back end: page table lookup, fault handling, counters and output register.
// Depends on tlbpt_pkg.
`default_nettype none
module tlbpt_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_valid,
    output logic                                  q_ready,
    input  wire tlbpt_pkg::work_t                 q_data,
    output tlbpt_pkg::refill_t                    refill,
    output logic                                  idle,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [tlbpt_pkg::ADDR_BITS-1:0]       physical_address,
    output logic [tlbpt_pkg::FRAME_OUT-1:0]       frame_number,
    output logic                                  tlb_hit,
    output logic                                  page_fault,
    output logic [tlbpt_pkg::CNT_BITS-1:0]        address_total,
    output logic [tlbpt_pkg::CNT_BITS-1:0]        hit_total,
    output logic [tlbpt_pkg::CNT_BITS-1:0]        fault_total
);
    localparam logic [tlbpt_pkg::CNT_BITS-1:0] CntMax = '1;

    tlbpt_pkg::frame_t pt_mem [tlbpt_pkg::PAGE_COUNT];
    logic [tlbpt_pkg::PAGE_COUNT-1:0] pvalid_reg;
    tlbpt_pkg::frame_t pt_rd_reg;
    tlbpt_pkg::frame_t free_reg;
    tlbpt_pkg::work_t  cur_reg;
    logic [tlbpt_pkg::CNT_BITS-1:0] acnt_reg, hcnt_reg, fcnt_reg;
    tlbpt_pkg::back_state_t state_reg, state_next;
    tlbpt_pkg::frame_t fr;
    logic take, fault;

    assign take  = (state_reg == tlbpt_pkg::ST_IDLE) && q_valid;
    assign fault = !cur_reg.hit && !pvalid_reg[cur_reg.page];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlbpt_pkg::ST_IDLE:   if (q_valid) state_next = tlbpt_pkg::ST_LOOKUP;
            tlbpt_pkg::ST_LOOKUP: state_next = tlbpt_pkg::ST_EMIT;
            tlbpt_pkg::ST_EMIT:   if (out_ready) state_next = tlbpt_pkg::ST_IDLE;
            default:              state_next = tlbpt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == tlbpt_pkg::ST_IDLE);
        idle      = (state_reg == tlbpt_pkg::ST_IDLE);
        out_valid = (state_reg == tlbpt_pkg::ST_EMIT);
        refill.push  = (state_reg == tlbpt_pkg::ST_LOOKUP) && fault;
        refill.page  = cur_reg.page;
        refill.frame = free_reg;
    end

    always_comb
    begin
        priority if (cur_reg.hit) fr = cur_reg.frame;
        else if (fault)          fr = free_reg;
        else                     fr = pt_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg   <= q_data;
            pt_rd_reg <= pt_mem[q_data.page];
        end
        if (refill.push)
            pt_mem[cur_reg.page] <= free_reg;
        if (state_reg == tlbpt_pkg::ST_LOOKUP)
        begin
            frame_number     <= tlbpt_pkg::FRAME_OUT'(fr);
            physical_address <= tlbpt_pkg::ADDR_BITS'({fr, cur_reg.offset});
            tlb_hit          <= cur_reg.hit;
            page_fault       <= fault;
            address_total    <= (acnt_reg == CntMax) ? acnt_reg : acnt_reg + 1'b1;
            hit_total        <= (cur_reg.hit && hcnt_reg != CntMax) ? hcnt_reg + 1'b1 : hcnt_reg;
            fault_total      <= (fault && fcnt_reg != CntMax) ? fcnt_reg + 1'b1 : fcnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tlbpt_pkg::ST_IDLE;
            pvalid_reg <= '0;
            free_reg   <= '0;
            acnt_reg   <= '0;
            hcnt_reg   <= '0;
            fcnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tlbpt_pkg::ST_LOOKUP)
            begin
                if (acnt_reg != CntMax) acnt_reg <= acnt_reg + 1'b1;
                if (cur_reg.hit && hcnt_reg != CntMax) hcnt_reg <= hcnt_reg + 1'b1;
                if (fault)
                begin
                    pvalid_reg[cur_reg.page] <= 1'b1;
                    free_reg <= free_reg + 1'b1;
                    if (fcnt_reg != CntMax) fcnt_reg <= fcnt_reg + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/tlb_page_table_translator_unit.sv
// Top level of the TLB / page table translator.
// Depends on tlbpt_pkg, tlbpt_front, tlbpt_back.
//   channel | signals                         | direction
//   in      | valid, ready, logical_address   | into block
//   out     | out_valid, out_ready, results   | out of block
// One item at a time: TLB search on accept, the back end then takes the item
// from the queue and reads the page table, and in its lookup state updates the
// page table and registers the result, which is valid in the emit state. The
// front holds ready low until the back end is idle again after the result is
// taken, and out_ready stalls delay the next accept for as long as they last.
// Reset clears the page-valid bits, TLB fill count, free frame and counters.
// No clearing pass; the block is ready right after reset.
`default_nettype none
module tlb_page_table_translator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [15:0] logical_address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      physical_address,
    output logic [7:0]       frame_number,
    output logic             tlb_hit,
    output logic             page_fault,
    output logic [31:0]      address_total,
    output logic [31:0]      hit_total,
    output logic [31:0]      fault_total
);
    logic q_valid, q_ready, back_idle;
    tlbpt_pkg::work_t   q_data;
    tlbpt_pkg::refill_t refill;

    tlbpt_front u_front (
        .clk, .rst_n, .valid, .ready, .logical_address,
        .q_valid, .q_ready, .q_data, .refill, .back_idle
    );

    tlbpt_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_data, .refill,
        .idle(back_idle), .out_valid, .out_ready,
        .physical_address, .frame_number, .tlb_hit, .page_fault,
        .address_total, .hit_total, .fault_total
    );
endmodule
`default_nettype wire

// File: sv/tlbpt_checker.sv
// Port-level checker for the translator, bound to the top level.
// Depends on tlb_page_table_translator_unit ports only.
`default_nettype none
module tlbpt_props (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] physical_address,
    input wire logic [7:0]  frame_number,
    input wire logic        tlb_hit,
    input wire logic        page_fault,
    input wire logic [31:0] address_total
);
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tlb_hit && page_fault))
        else $error("hit and fault together");
    a_frame_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (physical_address[15:8] == frame_number))
        else $error("frame mismatch");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (address_total != 32'd0))
        else $error("address count zero");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(physical_address)))
        else $error("output dropped");
    // one item in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && ready) |=> !ready)
        else $error("second item accepted while busy");
endmodule

bind tlb_page_table_translator_unit tlbpt_props u_chk (
    .clk, .rst_n, .valid, .ready, .out_valid, .out_ready,
    .physical_address, .frame_number, .tlb_hit, .page_fault, .address_total
);
`default_nettype wire
